@@ rtl/vfr_pkg.sv @@
// Shared constants, types and angle table of the vector frame rotation block
package vfr_pkg;

    // field widths
    localparam int COMP_W   = 18;
    localparam int AZ_W     = 16;
    localparam int OUT_W    = 19;

    // datapath widths: planar pair with guard bits, angle in 2^-32 turn
    localparam int GUARD    = 12;
    localparam int XY_W     = 32;
    localparam int Z_W      = 32;

    // CORDIC stage count and angle table
    localparam int STAGES_DEF = 16;
    localparam int ATAN_LEN   = 24;

    // gain compensation: multiply, round half up, drop 30 + GUARD bits
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam int RND_SHIFT = 30 + GUARD;
    localparam int PROD_W    = 62;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    // payload carried through the rotation stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [COMP_W-1:0]      axial;
    } t_rot;

endpackage

@@ rtl/vfr_in_if.sv @@
// Request channel interface: planar pair, axial component, azimuth, direction
interface vfr_in_if
    import vfr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] comp_a;
    logic signed [COMP_W-1:0] comp_b;
    logic signed [COMP_W-1:0] comp_axial;
    logic signed [AZ_W-1:0]   azimuth;
    logic                     to_cartesian;

    modport source (output valid, comp_a, comp_b, comp_axial, azimuth, to_cartesian,
                    input ready);
    modport sink   (input valid, comp_a, comp_b, comp_axial, azimuth, to_cartesian,
                    output ready);
endinterface

@@ rtl/vfr_out_if.sv @@
// Result channel interface: rotated planar pair and axial component
interface vfr_out_if
    import vfr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  rot_a;
    logic signed [OUT_W-1:0]  rot_b;
    logic signed [COMP_W-1:0] rot_axial;

    modport source (output valid, rot_a, rot_b, rot_axial, input ready);
    modport sink   (input valid, rot_a, rot_b, rot_axial, output ready);
endinterface

@@ rtl/vfr_prep.sv @@
// Input stage: angle select, quarter-turn pre-rotation, residual angle setup
module vfr_prep
    import vfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    vfr_in_if.sink i_req,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rot  o_data
);

    logic                   r_valid;
    t_rot                   r_data;
    t_rot                   n_data;
    logic [AZ_W-1:0]        w_t;
    logic [AZ_W-1:0]        w_u;
    logic signed [COMP_W:0] w_a;
    logic signed [COMP_W:0] w_b;
    logic signed [COMP_W:0] w_x;
    logic signed [COMP_W:0] w_y;
    logic                   w_adv;

    // rotation angle wraps modulo one turn; half turn negates to itself
    assign w_t = i_req.to_cartesian ? i_req.azimuth : AZ_W'(-i_req.azimuth);
    assign w_u = w_t + AZ_W'(8192);
    assign w_a = {i_req.comp_a[COMP_W-1], i_req.comp_a};
    assign w_b = {i_req.comp_b[COMP_W-1], i_req.comp_b};

    // exact rotation by the quarter-turn count
    always_comb begin
        case (w_u[15:14])
            2'd1: begin
                w_x = -w_b;
                w_y = w_a;
            end
            2'd2: begin
                w_x = -w_a;
                w_y = -w_b;
            end
            2'd3: begin
                w_x = w_b;
                w_y = -w_a;
            end
            default: begin
                w_x = w_a;
                w_y = w_b;
            end
        endcase
    end

    // residual in [-8192, 8191] scaled to 2^-32 turn
    always_comb begin
        n_data.x     = {{(XY_W-COMP_W-1-GUARD){w_x[COMP_W]}}, w_x, {GUARD{1'b0}}};
        n_data.y     = {{(XY_W-COMP_W-1-GUARD){w_y[COMP_W]}}, w_y, {GUARD{1'b0}}};
        n_data.z     = {{(Z_W-30){~w_u[13]}}, ~w_u[13], w_u[12:0], 16'b0};
        n_data.axial = i_req.comp_axial;
    end

    assign w_adv       = !r_valid || i_ready;
    assign i_req.ready = w_adv;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_req.valid;
        end
        if (w_adv && i_req.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/vfr_stage.sv @@
// One CORDIC rotation stage with its own register and valid bit
module vfr_stage
    import vfr_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rot i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rot o_data
);

    logic                   r_valid;
    t_rot                   r_data;
    t_rot                   n_data;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic                   w_adv;

    // floor shifts of the cross terms
    assign w_dx = i_data.y >>> STAGE_IDX;
    assign w_dy = i_data.x >>> STAGE_IDX;

    // micro-rotation toward zero residual angle
    always_comb begin
        n_data.axial = i_data.axial;
        if (!i_data.z[Z_W-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN_TABLE[STAGE_IDX];
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN_TABLE[STAGE_IDX];
        end
    end

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
        if (w_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/vfr_gain.sv @@
// Gain compensation: multiply stage, then round, saturate and output register
module vfr_gain
    import vfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rot     i_data,
    vfr_out_if.source o_res
);

    localparam int SH_W = PROD_W - RND_SHIFT;
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(64'sd1 <<< (RND_SHIFT - 1));

    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic [COMP_W-1:0]        r_p_axial;
    logic                     r_o_valid;
    logic signed [OUT_W-1:0]  r_rot_a;
    logic signed [OUT_W-1:0]  r_rot_b;
    logic [COMP_W-1:0]        r_rot_axial;
    logic signed [63:0]       w_mx;
    logic signed [63:0]       w_my;
    logic signed [PROD_W-1:0] w_sx;
    logic signed [PROD_W-1:0] w_sy;
    logic signed [OUT_W-1:0]  n_rot_a;
    logic signed [OUT_W-1:0]  n_rot_b;
    logic                     w_adv_p;
    logic                     w_adv_o;

    // clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SH_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v[SH_W-1] != v[SH_W-2]) begin
            r = v[SH_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // products with the gain constant
    assign w_mx = i_data.x * GAIN_Q30;
    assign w_my = i_data.y * GAIN_Q30;

    // round half up, floor shift
    assign w_sx    = (r_px + ROUND) >>> RND_SHIFT;
    assign w_sy    = (r_py + ROUND) >>> RND_SHIFT;
    assign n_rot_a = sat(w_sx[SH_W-1:0]);
    assign n_rot_b = sat(w_sy[SH_W-1:0]);

    assign w_adv_o = !r_o_valid || o_res.ready;
    assign w_adv_p = !r_p_valid || w_adv_o;
    assign o_ready = w_adv_p;

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_adv_p) begin
            r_p_valid <= i_valid;
        end
        if (w_adv_p && i_valid) begin
            r_px      <= w_mx[PROD_W-1:0];
            r_py      <= w_my[PROD_W-1:0];
            r_p_axial <= i_data.axial;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv_o) begin
            r_o_valid <= r_p_valid;
        end
        if (w_adv_o && r_p_valid) begin
            r_rot_a     <= n_rot_a;
            r_rot_b     <= n_rot_b;
            r_rot_axial <= r_p_axial;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.rot_a     = r_rot_a;
    assign o_res.rot_b     = r_rot_b;
    assign o_res.rot_axial = r_rot_axial;

endmodule

@@ rtl/vector_frame_rotation.sv @@
// Top level: CORDIC plane rotation between Cartesian and cylindrical frames
//
//   Port     Dir  Moves                                   Handshake
//   i_req    in   comp_a, comp_b, comp_axial, azimuth,    valid/ready
//                 to_cartesian
//   o_res    out  rot_a, rot_b, rot_axial                 valid/ready
//
// One request per cycle sustained while the output is not stalled; each result passes the
// prep register, one register per CORDIC stage, then the product and output registers.
// Synchronous active-low reset clears all valid bits; data registers hold.
// Each stage advances when it is empty or its successor takes its request, so a
// stalled output fills bubbles upstream and nothing is lost or repeated.
module vector_frame_rotation
    import vfr_pkg::*;
#(
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfr_in_if.sink    i_req,
    vfr_out_if.source o_res
);

    localparam int N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic w_valid [N+1];
    logic w_ready [N+1];
    t_rot w_data  [N+1];

    // angle setup and quarter-turn pre-rotation
    vfr_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // unrolled CORDIC stages
    for (genvar g = 0; g < N; g++) begin : g_stage
        vfr_stage #(
            .STAGE_IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // gain compensation and saturation
    vfr_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_data  (w_data[N]),
        .o_res   (o_res)
    );

endmodule

@@ bench/vfr_checker.sv @@
// Checker for the vector frame rotation block: predicts each result and compares it
module vfr_checker
    import vfr_pkg::*;
#(
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vfr_in_if    i_req,
    vfr_out_if   i_res,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // only the first 24 stages have an angle step
    localparam int  STEP_COUNT = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam longint GAIN    = 64'sd652032874;
    localparam longint OUT_HI  = 64'sd262143;
    localparam longint OUT_LO  = -64'sd262144;

    // atan(2^-i), in 2^-32 turn
    localparam longint ATAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic signed [OUT_W-1:0]  a;
        logic signed [OUT_W-1:0]  b;
        logic        [COMP_W-1:0] axial;
    } t_rotation;

    t_rotation rotations_due [$];
    t_rotation want;
    int        fail_count = 0;
    int        due_count  = 0;
    int        errs;

    assign o_errors  = fail_count;
    assign o_pending = due_count;

    // gain compensation, round half up, clamp to Q4.15
    function automatic logic signed [OUT_W-1:0] scale_saturate(input longint v);
        longint p;
        p = v * GAIN + (longint'(1) << 41);
        p = p >>> 42;
        if (p > OUT_HI)
            p = OUT_HI;
        if (p < OUT_LO)
            p = OUT_LO;
        return p[OUT_W-1:0];
    endfunction

    // quarter-turn pre-rotation, then CORDIC on the residual angle
    function automatic t_rotation rotate_planar(
        input logic signed [COMP_W-1:0] a_in,
        input logic signed [COMP_W-1:0] b_in,
        input logic        [COMP_W-1:0] axial,
        input logic signed [AZ_W-1:0]   az,
        input logic                     to_cart
    );
        logic [AZ_W-1:0]        turn;
        logic [AZ_W:0]          shifted;
        logic [1:0]             quarter;
        logic signed [AZ_W-1:0] resid;
        longint                 la, lb, x, y, z, dx, dy;
        t_rotation              res;
        la = a_in;
        lb = b_in;
        turn = to_cart ? az : -az;
        shifted = {1'b0, turn} + 17'd8192;
        quarter = shifted[15:14];
        resid = turn - {quarter, 14'd0};
        case (quarter)
            2'd1: begin
                x = -lb;
                y = la;
            end
            2'd2: begin
                x = -la;
                y = -lb;
            end
            2'd3: begin
                x = lb;
                y = -la;
            end
            default: begin
                x = la;
                y = lb;
            end
        endcase
        x = x * 4096;
        y = y * 4096;
        z = longint'(resid) * 65536;
        for (int i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        res.a     = scale_saturate(x);
        res.b     = scale_saturate(y);
        res.axial = axial;
        return res;
    endfunction

    // record each accepted request, check each accepted result against the oldest
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            errs = 0;
            if (i_req.valid && i_req.ready)
                rotations_due = {rotations_due, rotate_planar(i_req.comp_a, i_req.comp_b,
                    i_req.comp_axial, i_req.azimuth, i_req.to_cartesian)};
            if (i_res.valid && i_res.ready) begin
                if (rotations_due.size() == 0) begin
                    $error("result with no request outstanding: rot_a %0d rot_b %0d",
                           i_res.rot_a, i_res.rot_b);
                    errs++;
                end else begin
                    want = rotations_due.pop_front();
                    if (i_res.rot_a !== want.a) begin
                        $error("rot_a: expected %0d, got %0d", want.a, i_res.rot_a);
                        errs++;
                    end
                    if (i_res.rot_b !== want.b) begin
                        $error("rot_b: expected %0d, got %0d", want.b, i_res.rot_b);
                        errs++;
                    end
                    if (i_res.rot_axial !== want.axial) begin
                        $error("rot_axial: expected %0d, got %0d",
                               $signed(want.axial), i_res.rot_axial);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            due_count  <= rotations_due.size();
        end
    end

endmodule

@@ bench/tb_vector_frame_rotation.sv @@
// Testbench top for the vector frame rotation block: clock, reset, stimulus and verdict
module tb_vector_frame_rotation
    import vfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = STAGES_DEF;
    localparam int LATENCY    = STAGES + 3;
    localparam int NUM_RANDOM = 1950;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic req_burst = 1'b0;
    int   errors;
    int   pending;

    vfr_in_if  req_if ();
    vfr_out_if res_if ();

    vector_frame_rotation #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    vfr_checker #(.CORDIC_STAGES(STAGES)) checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .i_res     (res_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COMP_W-1:0] edge_component();
        case ($urandom_range(0, 4))
            0:       return 18'h1FFFF;
            1:       return 18'h20000;
            2:       return 18'h00000;
            3:       return 18'h3FFFF;
            default: return 18'h00001;
        endcase
    endfunction

    // hold one request until accepted, then maybe idle
    task automatic send_request(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b,
                                input logic [COMP_W-1:0] axial, input logic [AZ_W-1:0] az,
                                input logic to_cart);
        int gap;
        req_if.valid        <= 1'b1;
        req_if.comp_a       <= a;
        req_if.comp_b       <= b;
        req_if.comp_axial   <= axial;
        req_if.azimuth      <= az;
        req_if.to_cartesian <= to_cart;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        gap = req_burst ? 0 : idle_cycles();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random request: mostly uniform, some aimed at quadrant edges and extremes
    task automatic random_request();
        logic [COMP_W-1:0] a, b, axial;
        logic [AZ_W-1:0]   az;
        int                mode;
        mode  = $urandom_range(0, 9);
        a     = COMP_W'($urandom_range(0, 2**COMP_W - 1));
        b     = COMP_W'($urandom_range(0, 2**COMP_W - 1));
        axial = COMP_W'($urandom_range(0, 2**COMP_W - 1));
        az    = AZ_W'($urandom_range(0, 2**AZ_W - 1));
        case (mode)
            7: az = 16'(($urandom_range(0, 1) ? 8192 : 0) + 16384 * $urandom_range(0, 3)
                        + $urandom_range(0, 4) - 2);
            8: begin
                a = edge_component();
                b = edge_component();
            end
            9: begin
                a = edge_component();
                b = edge_component();
                case ($urandom_range(0, 4))
                    0:       az = 16'h8000;
                    1:       az = 16'h7FFF;
                    2:       az = 16'h0000;
                    3:       az = 16'h4000;
                    default: az = 16'hC000;
                endcase
            end
            default: ;
        endcase
        send_request(a, b, axial, az, 1'($urandom_range(0, 1)));
    endtask

    // result side back-pressure, with stall-free stretches
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        do
            @(posedge i_clk);
        while (i_rst_n !== 1'b1);
        forever begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            stall = idle_cycles();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int drain;
        req_if.valid        <= 1'b0;
        req_if.comp_a       <= '0;
        req_if.comp_b       <= '0;
        req_if.comp_axial   <= '0;
        req_if.azimuth      <= '0;
        req_if.to_cartesian <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, extremes, 45 degrees, quarter turns, half turn, edges
        send_request(18'd0, 18'd0, 18'd0, 16'd0, 1'b0);
        send_request(18'h1FFFF, 18'd0, 18'h1FFFF, 16'd0, 1'b0);
        send_request(18'h20000, 18'd0, 18'h20000, 16'd0, 1'b1);
        send_request(18'h1FFFF, 18'h1FFFF, 18'd5, 16'd8192, 1'b0);
        send_request(18'h1FFFF, 18'h1FFFF, 18'd6, 16'd8192, 1'b1);
        send_request(18'h20000, 18'h20000, 18'h3FFFF, -16'sd8192, 1'b0);
        send_request(18'h1FFFF, 18'h20000, 18'd1, 16'd16384, 1'b0);
        send_request(18'h1FFFF, 18'h20000, 18'd2, 16'd16384, 1'b1);
        send_request(18'd100000, -18'sd50000, 18'd3, -16'sd16384, 1'b0);
        send_request(18'h20000, 18'h1FFFF, 18'h2AAAA, 16'h8000, 1'b0);
        send_request(18'h20000, 18'h1FFFF, 18'h15555, 16'h8000, 1'b1);
        send_request(18'h1FFFF, 18'h1FFFF, 18'd7, 16'h7FFF, 1'b0);
        send_request(18'h1FFFF, 18'h1FFFF, 18'd8, 16'h7FFF, 1'b1);
        send_request(18'd65536, 18'd32768, 18'd9, 16'd8191, 1'b0);
        send_request(18'd65536, 18'd32768, 18'd10, -16'sd8193, 1'b1);
        send_request(-18'sd70000, 18'd12345, 18'd11, 16'd24575, 1'b0);
        send_request(-18'sd70000, 18'd12345, 18'd12, 16'd24576, 1'b1);
        send_request(18'd1, 18'h3FFFF, 18'd13, 16'd1, 1'b0);
        send_request(18'd1, 18'h3FFFF, 18'd14, 16'hFFFF, 1'b1);
        send_request(18'h20000, 18'h20000, 18'h20000, 16'd12345, 1'b1);

        // random: alternate normal stretches and back-to-back bursts
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0)
                req_burst <= ($urandom_range(0, 3) == 0);
            random_request();
        end
        req_if.valid <= 1'b0;

        // let the checker count the last request, drain, then watch for strays
        @(posedge i_clk);
        drain = 0;
        while (pending != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ vector_frame_rotation.f @@
rtl/vfr_pkg.sv
rtl/vfr_in_if.sv
rtl/vfr_out_if.sv
rtl/vfr_prep.sv
rtl/vfr_stage.sv
rtl/vfr_gain.sv
rtl/vector_frame_rotation.sv
bench/vfr_checker.sv
bench/tb_vector_frame_rotation.sv
